[rtl/lpc_pkg.sv]
// Package: shared types, codes and constants of the LRU page cache.
`default_nettype none
package lpc_pkg;
	localparam int ENTRIES_DEF = 1024;
	localparam int SECTORS_DEF = 16;
	localparam int STREAMS_DEF = 16;
	localparam int CAP_W = 11;

	localparam logic [3:0] CMD_PROBE = 4'd0;
	localparam logic [3:0] CMD_LOOKUP = 4'd1;
	localparam logic [3:0] CMD_INS_CLEAN = 4'd2;
	localparam logic [3:0] CMD_INS_DIRTY = 4'd3;
	localparam logic [3:0] CMD_UPDATE = 4'd4;
	localparam logic [3:0] CMD_MARK_WB = 4'd5;
	localparam logic [3:0] CMD_REMOVE = 4'd6;
	localparam logic [3:0] CMD_EVICT_LRU = 4'd7;
	localparam logic [3:0] CMD_EVICT_DIRTY = 4'd8;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_DUP = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	localparam logic [1:0] PG_CLEAN = 2'd0;
	localparam logic [1:0] PG_DIRTY = 2'd1;
	localparam logic [1:0] PG_WB = 2'd2;

	typedef struct packed {
		logic [3:0] command;
		logic [3:0] stream_no;
		logic [31:0] page_number;
		logic [63:0] page_content;
		logic [63:0] data_time;
		logic [15:0] sector_mask;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic hit;
		logic [3:0] slot_stream;
		logic [31:0] slot_page;
		logic [63:0] slot_content;
		logic [63:0] slot_time;
		logic [15:0] slot_sectors;
		logic [1:0] slot_state;
		logic [10:0] used_slots;
		logic is_full;
	} rsp_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_RD_SCAN,   // read key/valid at scan pointer
		OP_RD_ENTRY,  // read full entry + links at index register
		OP_RD_LINK,   // read links of a neighbor address
		OP_WR_ENTRY,  // write entry payload
		OP_WR_STATE,  // write state only
		OP_WR_OLDER,  // older_link[addr] <= data
		OP_WR_NEWER   // newer_link[addr] <= data
	} op_t;
endpackage
`default_nettype wire

[rtl/lru_page_cache_with_dirty_tracking.sv]
// Top level: LRU write-back page cache with dirty tracking.
`default_nettype none
// Command-style page cache keyed by {stream_no, page_number}. After reset the block
// clears the valid bit of every slot with busy high. Raise start with a request; it is
// taken at the first edge with busy low, and busy stays high while it runs. The result
// is posted on rsp with done high for exactly one cycle, the first cycle busy is low
// again, and rsp holds it until the next request is taken; the receiver cannot stall
// it, so capture it then. A new request may be taken in that same cycle. Every keyed
// command (probe through remove, both inserts) first runs a linear search of a
// single-port entry memory, slot after slot, until the key is found or the last slot
// is passed. After that: dispatch, then on a hit or an eviction an entry read, modify,
// for lookup and update an unlink and relink to the most recent end unless already
// there (remove and evictions unlink and drop it), and then the result is posted. An
// insert that misses scans again for a free slot, writes the entry there and links it
// unless the cache was empty. Dirty eviction walks from the least recent end. Capacity is
// written through cfg_valid / cfg_ready; cfg_ready is high whenever busy is low.
module lru_page_cache_with_dirty_tracking #(
	parameter int ENTRIES = lpc_pkg::ENTRIES_DEF,
	parameter int SECTORS_PER_PAGE = lpc_pkg::SECTORS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire lpc_pkg::req_t req,
	output logic done,
	output lpc_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [10:0] cfg_data
);
	localparam int AW = $clog2(ENTRIES);

	logic [10:0] cap_q;
	lpc_pkg::op_t op;
	logic [AW-1:0] addr, link_data, rd_older, rd_newer;
	logic [1:0] state_data, rd_state;
	logic set_valid, clr_valid, rd_valid;
	lpc_pkg::req_t req_q;
	logic [35:0] rd_key;
	logic [63:0] rd_content, rd_time;
	logic [15:0] rd_sectors;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	lpc_ctrl #(.ENTRIES(ENTRIES), .SECTORS(SECTORS_PER_PAGE)) u_ctrl (
		.clk, .arst_n, .start, .busy, .req_in(req), .cap(cap_q),
		.op, .addr, .link_data, .state_data, .set_valid, .clr_valid, .req_q,
		.rd_key, .rd_valid, .rd_content, .rd_time, .rd_sectors, .rd_state,
		.rd_older, .rd_newer, .done, .rsp
	);

	lpc_datapath #(.ENTRIES(ENTRIES), .SECTORS(SECTORS_PER_PAGE)) u_dp (
		.clk, .op, .addr, .link_data, .state_data, .set_valid, .clr_valid,
		.req(req_q), .rd_key, .rd_valid, .rd_content, .rd_time, .rd_sectors,
		.rd_state, .rd_older, .rd_newer
	);
endmodule
`default_nettype wire

[rtl/lpc_datapath.sv]
// Datapath: entry memories, link memories, valid bits and their registered reads.
`default_nettype none
module lpc_datapath #(
	parameter int ENTRIES = lpc_pkg::ENTRIES_DEF,
	parameter int SECTORS = lpc_pkg::SECTORS_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input wire logic clk,
	input wire lpc_pkg::op_t op,
	input wire logic [AW-1:0] addr,
	input wire logic [AW-1:0] link_data,
	input wire logic [1:0] state_data,
	input wire logic set_valid,
	input wire logic clr_valid,
	input wire lpc_pkg::req_t req,
	output logic [35:0] rd_key,
	output logic rd_valid,
	output logic [63:0] rd_content,
	output logic [63:0] rd_time,
	output logic [15:0] rd_sectors,
	output logic [1:0] rd_state,
	output logic [AW-1:0] rd_older,
	output logic [AW-1:0] rd_newer
);
	logic [35:0] key_mem [ENTRIES];
	logic [63:0] cont_mem [ENTRIES];
	logic [63:0] time_mem [ENTRIES];
	logic [15:0] sec_mem [ENTRIES];
	logic [1:0] st_mem [ENTRIES];
	logic [AW-1:0] older_mem [ENTRIES];
	logic [AW-1:0] newer_mem [ENTRIES];
	logic valid_mem [ENTRIES];   // cleared by the controller's pass after reset
	logic [15:0] smask;

	always_comb begin
		smask = 16'hffff;
		if (SECTORS < 16) smask = 16'((32'd1 << SECTORS) - 32'd1);
	end

	always_ff @(posedge clk) begin
		if (set_valid) begin
			valid_mem[addr] <= 1'b1;
		end else if (clr_valid) begin
			valid_mem[addr] <= 1'b0;
		end
		if (op == lpc_pkg::OP_WR_ENTRY) begin
			key_mem[addr] <= {req.stream_no, req.page_number};
			cont_mem[addr] <= req.page_content;
			time_mem[addr] <= req.data_time;
			sec_mem[addr] <= req.sector_mask & smask;
			st_mem[addr] <= state_data;
		end
		if (op == lpc_pkg::OP_WR_STATE) st_mem[addr] <= state_data;
		if (op == lpc_pkg::OP_WR_OLDER) older_mem[addr] <= link_data;
		if (op == lpc_pkg::OP_WR_NEWER) newer_mem[addr] <= link_data;
		rd_key <= key_mem[addr];
		rd_content <= cont_mem[addr];
		rd_time <= time_mem[addr];
		rd_sectors <= sec_mem[addr];
		rd_state <= st_mem[addr];
		rd_older <= older_mem[addr];
		rd_newer <= newer_mem[addr];
		rd_valid <= valid_mem[addr];
	end
endmodule
`default_nettype wire

[rtl/lpc_ctrl.sv]
// Controller: command sequencing, LRU list maintenance and result build.
`default_nettype none
module lpc_ctrl #(
	parameter int ENTRIES = lpc_pkg::ENTRIES_DEF,
	parameter int SECTORS = lpc_pkg::SECTORS_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire lpc_pkg::req_t req_in,
	input wire logic [10:0] cap,
	output lpc_pkg::op_t op,
	output logic [AW-1:0] addr,
	output logic [AW-1:0] link_data,
	output logic [1:0] state_data,
	output logic set_valid,
	output logic clr_valid,
	output lpc_pkg::req_t req_q,
	input wire logic [35:0] rd_key,
	input wire logic rd_valid,
	input wire logic [63:0] rd_content,
	input wire logic [63:0] rd_time,
	input wire logic [15:0] rd_sectors,
	input wire logic [1:0] rd_state,
	input wire logic [AW-1:0] rd_older,
	input wire logic [AW-1:0] rd_newer,
	output logic done,
	output lpc_pkg::rsp_t rsp
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_SCAN_W, S_DISPATCH, S_FREE, S_FREE_W, S_INS_W,
		S_RD_ENT, S_RD_ENT_W, S_MODIFY, S_UNL1, S_UNL2, S_LINK1, S_LINK2,
		S_DWALK, S_DWALK_W, S_DONE
	} state_t;

	localparam logic [AW:0] LAST = (AW+1)'(ENTRIES - 1);

	state_t state_q;
	logic [AW:0] ptr_q;          // scan pointer, one bit wider for end detect
	logic [AW-1:0] idx_q;
	logic found_q;
	logic [AW-1:0] mru_q, lru_q;
	logic [10:0] occ_q;
	logic [10:0] walk_q;
	logic [AW-1:0] old_q, new_q;
	logic [1:0] fin_q;           // 0 done, 1 relink front after unlink, 2 drop
	lpc_pkg::rsp_t r_q;
	logic [10:0] effcap;
	logic [15:0] smask;

	assign effcap = (32'(cap) > ENTRIES) ? 11'(ENTRIES) : cap;
	assign busy = (state_q != S_IDLE);
	assign rsp = r_q;

	always_comb begin
		smask = 16'hffff;
		if (SECTORS < 16) smask = 16'((32'd1 << SECTORS) - 32'd1);
	end

	// datapath command decode (combinational off registered state)
	always_comb begin
		op = lpc_pkg::OP_NONE;
		addr = idx_q;
		link_data = '0;
		state_data = lpc_pkg::PG_CLEAN;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		case (state_q)
			S_CLEAR: begin
				clr_valid = 1'b1;
				addr = ptr_q[AW-1:0];
			end
			S_SCAN, S_FREE: begin
				op = lpc_pkg::OP_RD_SCAN;
				addr = ptr_q[AW-1:0];
			end
			S_DWALK: begin
				op = lpc_pkg::OP_RD_ENTRY;
			end
			S_RD_ENT: op = lpc_pkg::OP_RD_ENTRY;
			S_INS_W: begin
				op = lpc_pkg::OP_WR_ENTRY;
				set_valid = 1'b1;
				state_data = (req_q.command == lpc_pkg::CMD_INS_DIRTY) ?
					lpc_pkg::PG_DIRTY : lpc_pkg::PG_CLEAN;
			end
			S_MODIFY: begin
				if (req_q.command == lpc_pkg::CMD_UPDATE) begin
					op = lpc_pkg::OP_WR_ENTRY;
					state_data = lpc_pkg::PG_DIRTY;
				end else if (req_q.command == lpc_pkg::CMD_MARK_WB) begin
					op = lpc_pkg::OP_WR_STATE;
					state_data = lpc_pkg::PG_WB;
				end
			end
			S_UNL1: begin
				// older_link[newer] <= older, unless idx is most recent
				if (idx_q != mru_q) begin
					op = lpc_pkg::OP_WR_OLDER;
					addr = new_q;
					link_data = old_q;
				end
			end
			S_UNL2: begin
				if (idx_q != lru_q) begin
					op = lpc_pkg::OP_WR_NEWER;
					addr = old_q;
					link_data = new_q;
				end
			end
			S_LINK1: begin
				op = lpc_pkg::OP_WR_OLDER;
				addr = idx_q;
				link_data = mru_q;
			end
			S_LINK2: begin
				op = lpc_pkg::OP_WR_NEWER;
				addr = mru_q;
				link_data = idx_q;
			end
			S_DONE: begin
				clr_valid = (fin_q == 2'd2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			mru_q <= '0;
			lru_q <= '0;
			occ_q <= '0;
			walk_q <= '0;
			old_q <= '0;
			new_q <= '0;
			fin_q <= '0;
			done <= 1'b0;
			r_q <= '0;
			req_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					// one valid bit per cycle after reset
					if (ptr_q == LAST) begin
						ptr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q <= req_in;
						r_q <= '0;
						found_q <= 1'b0;
						fin_q <= '0;
						ptr_q <= '0;
						if (req_in.command <= lpc_pkg::CMD_REMOVE) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DISPATCH;
						end
					end
				end
				S_SCAN: state_q <= S_SCAN_W;
				S_SCAN_W: begin
					// read data belongs to ptr_q
					if (rd_valid && rd_key == {req_q.stream_no, req_q.page_number}) begin
						found_q <= 1'b1;
						idx_q <= ptr_q[AW-1:0];
						state_q <= S_DISPATCH;
					end else if (ptr_q == LAST) begin
						state_q <= S_DISPATCH;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_DISPATCH: begin
					case (req_q.command)
						lpc_pkg::CMD_PROBE, lpc_pkg::CMD_LOOKUP, lpc_pkg::CMD_UPDATE,
						lpc_pkg::CMD_MARK_WB, lpc_pkg::CMD_REMOVE: begin
							if (!found_q) begin
								r_q.status <= lpc_pkg::ST_MISS;
								state_q <= S_DONE;
							end else begin
								r_q.hit <= 1'b1;
								state_q <= S_RD_ENT;
							end
						end
						lpc_pkg::CMD_INS_CLEAN, lpc_pkg::CMD_INS_DIRTY: begin
							if (found_q) begin
								r_q.status <= lpc_pkg::ST_DUP;
								r_q.hit <= 1'b1;
								state_q <= S_RD_ENT;
							end else if (occ_q >= effcap) begin
								r_q.status <= lpc_pkg::ST_FULL;
								state_q <= S_DONE;
							end else begin
								ptr_q <= '0;
								state_q <= S_FREE;
							end
						end
						lpc_pkg::CMD_EVICT_LRU: begin
							if (occ_q == '0) begin
								r_q.status <= lpc_pkg::ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								idx_q <= lru_q;
								state_q <= S_RD_ENT;
							end
						end
						lpc_pkg::CMD_EVICT_DIRTY: begin
							if (occ_q == '0) begin
								r_q.status <= lpc_pkg::ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								idx_q <= lru_q;
								walk_q <= '0;
								state_q <= S_DWALK;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_FREE: state_q <= S_FREE_W;
				S_FREE_W: begin
					if (!rd_valid) begin
						idx_q <= ptr_q[AW-1:0];
						state_q <= S_INS_W;
					end else if (ptr_q == LAST) begin
						r_q.status <= lpc_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						state_q <= S_FREE;
					end
				end
				S_INS_W: begin
					r_q.slot_stream <= req_q.stream_no;
					r_q.slot_page <= req_q.page_number;
					r_q.slot_content <= req_q.page_content;
					r_q.slot_time <= req_q.data_time;
					r_q.slot_sectors <= req_q.sector_mask & smask;
					r_q.slot_state <= (req_q.command == lpc_pkg::CMD_INS_DIRTY) ?
						lpc_pkg::PG_DIRTY : lpc_pkg::PG_CLEAN;
					occ_q <= occ_q + 1'b1;
					if (occ_q == '0) begin
						mru_q <= idx_q;
						lru_q <= idx_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LINK1;
					end
				end
				S_DWALK: state_q <= S_DWALK_W;
				S_DWALK_W: begin
					if (rd_state == lpc_pkg::PG_DIRTY) begin
						state_q <= S_RD_ENT;
					end else if (walk_q + 1'b1 >= occ_q) begin
						r_q.status <= lpc_pkg::ST_EMPTY;
						state_q <= S_DONE;
					end else begin
						walk_q <= walk_q + 1'b1;
						idx_q <= rd_newer;
						state_q <= S_DWALK;
					end
				end
				S_RD_ENT: state_q <= S_RD_ENT_W;
				S_RD_ENT_W: begin
					r_q.slot_stream <= rd_key[35:32];
					r_q.slot_page <= rd_key[31:0];
					r_q.slot_content <= rd_content;
					r_q.slot_time <= rd_time;
					r_q.slot_sectors <= rd_sectors;
					r_q.slot_state <= rd_state;
					old_q <= rd_older;
					new_q <= rd_newer;
					state_q <= S_MODIFY;
				end
				S_MODIFY: begin
					case (req_q.command)
						lpc_pkg::CMD_LOOKUP: begin
							if (idx_q != mru_q) begin
								fin_q <= 2'd1;
								state_q <= S_UNL1;
							end else begin
								state_q <= S_DONE;
							end
						end
						lpc_pkg::CMD_UPDATE: begin
							r_q.slot_content <= req_q.page_content;
							r_q.slot_time <= req_q.data_time;
							r_q.slot_sectors <= req_q.sector_mask & smask;
							r_q.slot_state <= lpc_pkg::PG_DIRTY;
							if (idx_q != mru_q) begin
								fin_q <= 2'd1;
								state_q <= S_UNL1;
							end else begin
								state_q <= S_DONE;
							end
						end
						lpc_pkg::CMD_MARK_WB: begin
							r_q.slot_state <= lpc_pkg::PG_WB;
							state_q <= S_DONE;
						end
						lpc_pkg::CMD_REMOVE, lpc_pkg::CMD_EVICT_LRU,
						lpc_pkg::CMD_EVICT_DIRTY: begin
							fin_q <= 2'd2;
							state_q <= S_UNL1;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_UNL1: begin
					if (idx_q == mru_q) mru_q <= old_q;
					state_q <= S_UNL2;
				end
				S_UNL2: begin
					if (idx_q == lru_q) lru_q <= new_q;
					if (fin_q == 2'd1) begin
						state_q <= S_LINK1;
					end else begin
						occ_q <= occ_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_LINK1: state_q <= S_LINK2;
				S_LINK2: begin
					mru_q <= idx_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					r_q.used_slots <= occ_q;
					r_q.is_full <= (occ_q >= effcap);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
